/* rtl/core/uit_pkg.sv */
// shared types, codes and defaults of the unique item table
package uit_pkg;

    // default sizes and reset value of the capacity register
    localparam int DEPTH_DEFAULT      = 64;
    localparam int ITEM_WIDTH_DEFAULT = 32;
    localparam logic [6:0] CAPACITY_RESET = 7'd50;

    // widest item on the ports and widest count for the deepest table
    localparam int KEY_MAX_W = 32;
    localparam int CNT_MAX_W = 11;

    // operation codes
    typedef enum logic [2:0] {
        K_INSERT = 3'd0,
        K_DELETE = 3'd1,
        K_READ   = 3'd2,
        K_FIND   = 3'd3,
        K_CLEAR  = 3'd4
    } kind_t;

    // status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_DUP      = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_OOB      = 3'd4
    } status_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic                 mode_read;
        logic                 write_en;
        logic                 shift_en;
        logic [CNT_MAX_W-1:0] count;
        logic [CNT_MAX_W-1:0] where;
        logic [CNT_MAX_W-1:0] pos;
        logic [KEY_MAX_W-1:0] key;
    } cell_ctl_t;

    // search wave handed from each cell to its lower neighbor
    typedef struct packed {
        logic                 hit;
        logic [CNT_MAX_W-1:0] index;
        logic [KEY_MAX_W-1:0] data;
    } wave_t;

endpackage

/* rtl/core/uit_cell.sv */
// one table entry with its local compare and its stage of the search wave
module uit_cell #(
    parameter int DEPTH      = 64,
    parameter int ITEM_WIDTH = 32,
    parameter int INDEX      = 0
) (
    input  logic                                        clk,
    input  uit_pkg::cell_ctl_t                          ctl,
    input  uit_pkg::wave_t                              wave_in,
    output uit_pkg::wave_t                              wave_out,
    input  logic [(ITEM_WIDTH < 32 ? ITEM_WIDTH : 32)-1:0] next_entry,
    output logic [(ITEM_WIDTH < 32 ? ITEM_WIDTH : 32)-1:0] entry
);
    import uit_pkg::*;

    localparam int KEY_W   = (ITEM_WIDTH < KEY_MAX_W) ? ITEM_WIDTH : KEY_MAX_W;
    localparam bit IS_LAST = (INDEX == DEPTH - 1);
    localparam logic [CNT_MAX_W-1:0] MY_IDX = CNT_MAX_W'(INDEX);

    logic [KEY_W-1:0] entry_reg;
    logic [KEY_W-1:0] entry_next;
    wave_t            wave_reg;
    wave_t            wave_next;
    logic             in_use;
    logic             match;

    // local match against the broadcast key or read position
    always_comb
    begin
        in_use = (MY_IDX < ctl.count);
        if (ctl.mode_read)
        begin
            match = in_use && (ctl.pos == MY_IDX);
        end
        else
        begin
            match = in_use && (entry_reg == ctl.key[KEY_W-1:0]);
        end
    end

    // lowest matching cell wins as the wave moves toward cell zero
    always_comb
    begin
        if (match)
        begin
            wave_next.hit   = 1'b1;
            wave_next.index = MY_IDX;
            wave_next.data  = KEY_MAX_W'(entry_reg);
        end
        else
        begin
            wave_next = wave_in;
        end
    end

    // append writes at the count, delete pulls the upper neighbor down
    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.write_en && (ctl.count == MY_IDX))
        begin
            entry_next = ctl.key[KEY_W-1:0];
        end
        else if (ctl.shift_en && (MY_IDX >= ctl.where))
        begin
            entry_next = IS_LAST ? entry_reg : next_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        wave_reg  <= wave_next;
    end

    assign entry    = entry_reg;
    assign wave_out = wave_reg;

endmodule

/* rtl/core/uit_ctrl.sv */
// sequencer: takes items, waits out the search wave, updates the count, holds results
module uit_ctrl #(
    parameter int DEPTH      = 64,
    parameter int ITEM_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         kind,
    input  logic [31:0]        item_value,
    input  logic [5:0]         position,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         status,
    output logic [31:0]        item_out,
    output logic               found,
    output logic [5:0]         found_index,
    output logic [6:0]         count_now,
    output logic               is_empty,
    output logic               is_full,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_wdata,
    input  uit_pkg::wave_t     wave,
    output uit_pkg::cell_ctl_t ctl
);
    import uit_pkg::*;

    localparam int KEY_W = (ITEM_WIDTH < KEY_MAX_W) ? ITEM_WIDTH : KEY_MAX_W;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [6:0]        cap_reg;
    logic [2:0]        kind_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [5:0]        pos_reg;

    logic              out_valid_reg, out_valid_next;
    logic [2:0]        status_reg, status_next;
    logic [KEY_W-1:0]  item_out_reg, item_out_next;
    logic              found_reg, found_next;
    logic [5:0]        found_index_reg, found_index_next;
    logic [6:0]        count_now_reg, count_now_next;
    logic              empty_reg, empty_next;
    logic              full_reg, full_next;

    logic              accept;
    logic              finish;
    logic              write_en, shift_en;
    logic [CMP_W-1:0]  cap_ext, eff_cap;
    logic              full_now;

    // capacity above the depth acts as the depth
    always_comb
    begin
        cap_ext  = CMP_W'(cap_reg);
        eff_cap  = (cap_ext > DEPTH_C) ? DEPTH_C : cap_ext;
        full_now = (CMP_W'(count_reg) >= eff_cap);
    end

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign finish   = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    scan_next = '0;
                    if ((kind == K_INSERT) || (kind == K_DELETE) ||
                        (kind == K_READ) || (kind == K_FIND))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end
            S_SCAN:
            begin
                scan_next = scan_reg + 1'b1;
                if (scan_reg == SCAN_LAST)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // result and table update once the wave has reached cell zero
    always_comb
    begin
        count_next       = count_reg;
        write_en         = 1'b0;
        shift_en         = 1'b0;
        status_next      = ST_OK;
        item_out_next    = '0;
        found_next       = 1'b0;
        found_index_next = '0;
        unique case (kind_reg)
            K_INSERT:
            begin
                if (full_now)
                begin
                    status_next = ST_FULL;
                end
                else if (wave.hit)
                begin
                    status_next = ST_DUP;
                end
                else
                begin
                    write_en   = finish;
                    count_next = count_reg + 1'b1;
                end
            end
            K_DELETE:
            begin
                if (!wave.hit)
                begin
                    status_next = ST_NOTFOUND;
                end
                else
                begin
                    shift_en   = finish;
                    count_next = count_reg - 1'b1;
                end
            end
            K_READ:
            begin
                if (wave.hit)
                begin
                    item_out_next = wave.data[KEY_W-1:0];
                end
                else
                begin
                    status_next = ST_OOB;
                end
            end
            K_FIND:
            begin
                if (wave.hit)
                begin
                    found_next       = 1'b1;
                    found_index_next = 6'(wave.index);
                end
                else
                begin
                    status_next = ST_NOTFOUND;
                end
            end
            K_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        count_now_next = 7'(count_next);
        empty_next     = (count_next == '0);
        full_next      = (CMP_W'(count_next) >= eff_cap);
    end

    // output register handshake
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    // broadcast to the cells
    always_comb
    begin
        ctl.mode_read = (kind_reg == K_READ);
        ctl.write_en  = write_en;
        ctl.shift_en  = shift_en;
        ctl.count     = CNT_MAX_W'(count_reg);
        ctl.where     = wave.index;
        ctl.pos       = CNT_MAX_W'(pos_reg);
        ctl.key       = KEY_MAX_W'(key_reg);
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= CAPACITY_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
            if (finish)
            begin
                count_reg <= count_next;
            end
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg <= kind;
            key_reg  <= item_value[KEY_W-1:0];
            pos_reg  <= position;
        end
        if (finish)
        begin
            status_reg      <= status_next;
            item_out_reg    <= item_out_next;
            found_reg       <= found_next;
            found_index_reg <= found_index_next;
            count_now_reg   <= count_now_next;
            empty_reg       <= empty_next;
            full_reg        <= full_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign item_out    = 32'(item_out_reg);
    assign found       = found_reg;
    assign found_index = found_index_reg;
    assign count_now   = count_now_reg;
    assign is_empty    = empty_reg;
    assign is_full     = full_reg;

endmodule

/* rtl/core/unique_item_table.sv */
// top level of the unique item table: a row of entry cells and the sequencer
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid, in_stall, kind, item_value, position   | in
//  out     | out_valid, out_stall, status, item_out, found,   | out
//          | found_index, count_now, is_empty, is_full        |
//  cfg     | cfg_we, cfg_wdata (capacity)                     | in
//
// insert, delete, read and find wait out the search wave, which moves one cell
// per cycle from the top cell down to cell zero; clear and unknown kinds skip
// the search. one item is at work at a time.
// reset clears the count and loads the capacity; entries are not cleared.
// a result waits in the output register under out_stall while the next item
// is taken and searched; it stalls only in its done state.
module unique_item_table #(
    parameter int DEPTH      = uit_pkg::DEPTH_DEFAULT,
    parameter int ITEM_WIDTH = uit_pkg::ITEM_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  kind,
    input  logic [31:0] item_value,
    input  logic [5:0]  position,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [31:0] item_out,
    output logic        found,
    output logic [5:0]  found_index,
    output logic [6:0]  count_now,
    output logic        is_empty,
    output logic        is_full,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata
);
    import uit_pkg::*;

    localparam int KEY_W = (ITEM_WIDTH < KEY_MAX_W) ? ITEM_WIDTH : KEY_MAX_W;

    cell_ctl_t        ctl;
    wave_t            wave_bus  [DEPTH];
    logic [KEY_W-1:0] entry_bus [DEPTH];

    // sequencer
    uit_ctrl #(
        .DEPTH      (DEPTH),
        .ITEM_WIDTH (ITEM_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .item_value  (item_value),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .item_out    (item_out),
        .found       (found),
        .found_index (found_index),
        .count_now   (count_now),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .wave        (wave_bus[0]),
        .ctl         (ctl)
    );

    // row of cells, each linked to its upper neighbor
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        wave_t            wave_up;
        logic [KEY_W-1:0] entry_up;

        if (i == DEPTH - 1)
        begin : g_top
            assign wave_up  = '0;
            assign entry_up = entry_bus[i];
        end
        else
        begin : g_mid
            assign wave_up  = wave_bus[i + 1];
            assign entry_up = entry_bus[i + 1];
        end

        uit_cell #(
            .DEPTH      (DEPTH),
            .ITEM_WIDTH (ITEM_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .wave_in    (wave_up),
            .wave_out   (wave_bus[i]),
            .next_entry (entry_up),
            .entry      (entry_bus[i])
        );
    end

endmodule

/* dv/testbench.sv */
// self-checking testbench for the unique item table: directed and random table operations
`timescale 1ns / 100ps

module testbench;
    import uit_pkg::*;

    localparam int TABLE_DEPTH = uit_pkg::DEPTH_DEFAULT;
    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = TABLE_DEPTH + 4;

    // kinds with no operation behind them
    localparam logic [2:0] K_SPARE5 = 3'd5;
    localparam logic [2:0] K_SPARE6 = 3'd6;
    localparam logic [2:0] K_SPARE7 = 3'd7;

    // one expected result item
    typedef struct {
        status_t     status;
        logic [31:0] item_out;
        logic        found;
        logic [5:0]  found_index;
        logic [6:0]  count_now;
        logic        is_empty;
        logic        is_full;
    } table_reply_t;

    // mirror of the table contents and the queue of replies it predicts
    class table_tracker;
        logic [31:0]  entries [TABLE_DEPTH];
        int           count;
        int           capacity;
        table_reply_t pending [$];
        int           failures;
        int           replies_seen;

        function new();
            count        = 0;
            capacity     = int'(CAPACITY_RESET);
            failures     = 0;
            replies_seen = 0;
        endfunction

        // first position holding the item, -1 when absent
        function int locate(logic [31:0] v);
            for (int i = 0; i < count; i++)
            begin
                if (entries[i] == v)
                    return i;
            end
            return -1;
        endfunction

        // apply one accepted operation and queue the reply it must produce
        function void note_op(logic [2:0] k, logic [31:0] v, logic [5:0] p);
            table_reply_t r;
            int hit;
            int lim;
            r.status      = ST_OK;
            r.item_out    = '0;
            r.found       = 1'b0;
            r.found_index = '0;
            lim = (capacity > TABLE_DEPTH) ? TABLE_DEPTH : capacity;
            hit = locate(v);
            case (k)
                K_INSERT:
                begin
                    if (count >= lim)
                        r.status = ST_FULL;
                    else if (hit >= 0)
                        r.status = ST_DUP;
                    else
                    begin
                        entries[count] = v;
                        count++;
                    end
                end
                K_DELETE:
                begin
                    if (hit < 0)
                        r.status = ST_NOTFOUND;
                    else
                    begin
                        for (int i = hit; i + 1 < count; i++)
                            entries[i] = entries[i + 1];
                        count--;
                    end
                end
                K_READ:
                begin
                    if (int'(p) >= count)
                        r.status = ST_OOB;
                    else
                        r.item_out = entries[p];
                end
                K_FIND:
                begin
                    if (hit >= 0)
                    begin
                        r.found       = 1'b1;
                        r.found_index = 6'(hit);
                    end
                    else
                        r.status = ST_NOTFOUND;
                end
                K_CLEAR:
                    count = 0;
                default:
                    ;
            endcase
            r.count_now = 7'(count);
            r.is_empty  = (count == 0);
            r.is_full   = (count >= lim);
            pending.push_back(r);
        endfunction

        // compare one accepted result item with the oldest prediction
        function void check_reply(logic [2:0] st, logic [31:0] io, logic fnd,
                                  logic [5:0] fi, logic [6:0] cn, logic em, logic fu);
            table_reply_t e;
            replies_seen++;
            if (pending.size() == 0)
            begin
                if (failures < 10)
                    $display("result %0d arrived with nothing pending", replies_seen);
                failures++;
                return;
            end
            e = pending.pop_front();
            if (st !== e.status || io !== e.item_out || fnd !== e.found ||
                fi !== e.found_index || cn !== e.count_now || em !== e.is_empty ||
                fu !== e.is_full)
            begin
                if (failures < 10)
                begin
                    $display("result %0d expected: status=%0d item=%h found=%0d idx=%0d cnt=%0d empty=%0d full=%0d",
                             replies_seen, e.status, e.item_out, e.found, e.found_index,
                             e.count_now, e.is_empty, e.is_full);
                    $display("result %0d actual:   status=%0d item=%h found=%0d idx=%0d cnt=%0d empty=%0d full=%0d",
                             replies_seen, st, io, fnd, fi, cn, em, fu);
                end
                failures++;
            end
        endfunction
    endclass

    logic        clk        = 1'b0;
    logic        rst_n      = 1'b0;
    logic        in_valid   = 1'b0;
    logic        in_stall;
    logic [2:0]  kind       = K_INSERT;
    logic [31:0] item_value = '0;
    logic [5:0]  position   = '0;
    logic        out_valid;
    logic        out_stall  = 1'b0;
    logic [2:0]  status;
    logic [31:0] item_out;
    logic        found;
    logic [5:0]  found_index;
    logic [6:0]  count_now;
    logic        is_empty;
    logic        is_full;
    logic        cfg_we     = 1'b0;
    logic [6:0]  cfg_wdata  = '0;

    logic        send_gaps_on   = 1'b0;
    logic        recv_stalls_on = 1'b0;
    int          stall_left     = 0;
    int          cycles         = 0;

    table_tracker tracker = new();

    unique_item_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .item_value  (item_value),
        .position    (position),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .item_out    (item_out),
        .found       (found),
        .found_index (found_index),
        .count_now   (count_now),
        .is_empty    (is_empty),
        .is_full     (is_full),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata)
    );

    // clock
    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // random receiver stall bursts
    always @(posedge clk)
    begin
        if (recv_stalls_on && stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (recv_stalls_on && $urandom_range(0, 5) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 4);
        end
        else
            out_stall <= 1'b0;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_reply(status, item_out, found, found_index, count_now,
                                is_empty, is_full);
    end

    // drive one operation and hold it until accepted
    task automatic send_op(input logic [2:0] k, input logic [31:0] v, input logic [5:0] p);
        int gap;
        in_valid   <= 1'b1;
        kind       <= k;
        item_value <= v;
        position   <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_op(k, v, p);
        if (send_gaps_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // hold off the sender until every pending reply is back
    task automatic drain_replies();
        in_valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    // write the capacity register while the table is idle
    task automatic set_capacity(input logic [6:0] c);
        drain_replies();
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.capacity = int'(c);
    endtask

    // choose a random operation biased toward items the table holds
    task automatic pick_op(input int ins_w, output logic [2:0] k, output logic [31:0] v,
                           output logic [5:0] p);
        int n;
        int r;
        int s;
        int pick;
        n = tracker.count;
        r = $urandom_range(0, 99);
        if (r < ins_w)
            k = K_INSERT;
        else
        begin
            s = (r - ins_w) * 20 / (100 - ins_w);
            if (s < 7)
                k = K_DELETE;
            else if (s < 13)
                k = K_READ;
            else if (s < 18)
                k = K_FIND;
            else if (s == 18)
                k = K_CLEAR;
            else
                k = 3'(K_SPARE5 + $urandom_range(0, 2));
        end
        pick = $urandom_range(0, 5);
        if (n > 0 && ((k == K_INSERT) ? (pick == 0) : (pick < 4)))
            v = tracker.entries[$urandom_range(0, n - 1)];
        else if ($urandom_range(0, 1) == 0)
            v = 32'($urandom_range(0, 15));
        else
            v = $urandom;
        if (n > 0 && $urandom_range(0, 3) != 0)
            p = 6'($urandom_range(0, n - 1));
        else
            p = 6'($urandom_range(0, 63));
    endtask

    // one random phase at a fixed capacity
    task automatic run_phase(input logic [6:0] c, input int n_ops, input int ins_w,
                             input bit quiet);
        logic [2:0]  k;
        logic [31:0] v;
        logic [5:0]  p;
        set_capacity(c);
        send_gaps_on   <= !quiet && ($urandom_range(0, 3) != 0);
        recv_stalls_on <= !quiet && ($urandom_range(0, 3) != 0);
        repeat (n_ops)
        begin
            pick_op(ins_w, k, v, p);
            send_op(k, v, p);
        end
    endtask

    initial
    begin
        // reset
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_gaps_on   <= 1'b1;
        recv_stalls_on <= 1'b1;

        // empty table at reset capacity
        send_op(K_READ, 32'h0, 6'd0);
        send_op(K_FIND, 32'h0, 6'd0);
        send_op(K_DELETE, 32'h5, 6'd0);
        // value extremes and duplicate refusal
        send_op(K_INSERT, 32'h0000_0000, 6'd0);
        send_op(K_INSERT, 32'hFFFF_FFFF, 6'd63);
        send_op(K_INSERT, 32'h0000_0000, 6'd0);
        send_op(K_INSERT, 32'h1234_5678, 6'd0);
        send_op(K_FIND, 32'hFFFF_FFFF, 6'd0);
        // reads inside and past the count
        send_op(K_READ, 32'h0, 6'd0);
        send_op(K_READ, 32'h0, 6'd2);
        send_op(K_READ, 32'h0, 6'd63);
        send_op(K_READ, 32'h0, 6'd3);
        // delete closes the gap
        send_op(K_DELETE, 32'h0000_0000, 6'd0);
        send_op(K_READ, 32'h0, 6'd0);
        // kinds with no operation
        send_op(K_SPARE5, 32'hFFFF_FFFF, 6'd63);
        send_op(K_SPARE6, 32'h0, 6'd0);
        send_op(K_SPARE7, 32'h1234_5678, 6'd1);
        // clear empties the table
        send_op(K_CLEAR, 32'h0, 6'd0);
        send_op(K_READ, 32'h0, 6'd0);
        send_op(K_INSERT, 32'hA5A5_A5A5, 6'd0);
        send_op(K_INSERT, 32'h5A5A_5A5A, 6'd0);

        // capacity lowered below the count; full wins over duplicate
        set_capacity(7'd1);
        send_op(K_INSERT, 32'hCAFE_0001, 6'd0);
        send_op(K_INSERT, 32'hA5A5_A5A5, 6'd0);
        send_op(K_FIND, 32'h5A5A_5A5A, 6'd0);
        send_op(K_DELETE, 32'hA5A5_A5A5, 6'd0);

        // capacity zero is always full
        set_capacity(7'd0);
        send_op(K_INSERT, 32'h0BAD_F00D, 6'd0);
        send_op(K_CLEAR, 32'h0, 6'd0);
        send_op(K_INSERT, 32'h0BAD_F00D, 6'd0);

        // random phases over several capacities, the extremes among them
        run_phase(7'd64, 120, 85, 1'b0);
        run_phase(7'd1, 40, 50, 1'b0);
        run_phase(7'd0, 25, 50, 1'b0);
        run_phase(7'd2, 40, 50, 1'b0);
        run_phase(7'd127, 120, 80, 1'b0);
        run_phase(7'd7, 60, 45, 1'b0);
        run_phase(7'd65, 40, 60, 1'b0);
        run_phase(7'd33, 60, 55, 1'b0);
        run_phase(7'd5, 40, 40, 1'b0);
        run_phase(7'd50, 60, 50, 1'b1);

        // wait for the last replies, then let the block settle
        drain_replies();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (tracker.failures == 0 && tracker.pending.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/uit_pkg.sv
rtl/core/uit_cell.sv
rtl/core/uit_ctrl.sv
rtl/core/unique_item_table.sv
dv/testbench.sv
